FILE: src/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

  typedef enum logic [1:0] {
    MODE_AGG    = 2'd0,
    MODE_STRICT = 2'd1,
    MODE_CSV    = 2'd2,
    MODE_FIXED  = 2'd3
  } split_mode_e;

  typedef enum logic [2:0] {
    REG_SPLIT_MODE   = 3'd0,
    REG_DELIM_BYTES  = 3'd1,
    REG_DELIM_COUNT  = 3'd2,
    REG_MAX_FIELDS   = 3'd3,
    REG_IGNORE_LEAD  = 3'd4,
    REG_STRIP_QUOTES = 3'd5,
    REG_COL_WIDTHS   = 3'd6,
    REG_COL_COUNT    = 3'd7
  } cfg_reg_e;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  localparam logic [7:0] COMMA_BYTE = 8'h2C;
  localparam logic [7:0] QUOTE_BYTE = 8'h22;

  localparam logic [2:0] MAX_DELIMS  = 3'd4;
  localparam logic [3:0] MAX_COLUMNS = 4'd8;

  localparam logic [31:0] DELIM_BYTES_RST = 32'd2313;
  localparam logic [2:0]  DELIM_COUNT_RST = 3'd2;

  function automatic logic [7:0] col_width(input logic [63:0] widths, input logic [2:0] k);
    return widths[{k, 3'b000} +: 8];
  endfunction

endpackage

FILE: src/line_field_splitter_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   char_byte_i, end_of_line_i
// out       output     out_valid_o / out_ready_i field_valid_o, field_number_o,
//                                                field_start_o, field_length_o,
//                                                line_done_o, line_too_long_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A byte stays in the input register until it has moved out every result it
// produces; a byte that produces none does not wait on the output.
// In fixed mode one byte can close up to eight columns; the column stepper
// handles one column per cycle unless stalled; a csv comma at eol adds a field.
// Reset clears the line state and loads the register defaults; no clearing pass.
// A stalled output holds the result register; the input register still takes
// a new beat once the byte in it has moved its last result out.

module line_field_splitter_top
  import lfs_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_byte_i,
  input  logic              end_of_line_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              field_valid_o,
  output logic [7:0]        field_number_o,
  output logic [11:0]       field_start_o,
  output logic [12:0]       field_length_o,
  output logic              line_done_o,
  output logic              line_too_long_o
);

  localparam int PW = $clog2(LINE_BYTES);
  localparam int OW = $clog2(LINE_BYTES + 1);
  localparam int CW = $clog2(LINE_BYTES + 256);
  localparam logic [OW-1:0] LB_O   = OW'(LINE_BYTES);
  localparam logic [CW-1:0] LB_C   = CW'(LINE_BYTES);
  localparam logic [PW-1:0] LAST_P = PW'(LINE_BYTES - 1);
  localparam logic [CW-1:0] LAST_C = CW'(LINE_BYTES - 1);

  function automatic logic [3:0][7:0] rec_edges(input logic [3:0][7:0] e,
                                                input logic [7:0] c,
                                                input logic [PW-1:0] p,
                                                input logic [CW-1:0] cs);
    logic [3:0][7:0] r;
    r = e;
    if (CW'(p) == cs) r[0] = c;
    if (CW'(p) == cs + CW'(1)) r[1] = c;
    r[2] = e[3];
    r[3] = c;
    return r;
  endfunction

  // Configuration registers.
  split_mode_e mode_q;
  logic [31:0] dbytes_q;
  logic [2:0]  dcount_q;
  logic [7:0]  maxf_q;
  logic        ign_q;
  logic        strip_q;
  logic [63:0] cwidths_q;
  logic [3:0]  ccount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_AGG;
      dbytes_q  <= DELIM_BYTES_RST;
      dcount_q  <= DELIM_COUNT_RST;
      maxf_q    <= '0;
      ign_q     <= 1'b0;
      strip_q   <= 1'b0;
      cwidths_q <= '0;
      ccount_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPLIT_MODE:   mode_q    <= split_mode_e'(cfg_wdata_i[1:0]);
        REG_DELIM_BYTES:  dbytes_q  <= cfg_wdata_i[31:0];
        REG_DELIM_COUNT:  dcount_q  <= cfg_wdata_i[2:0];
        REG_MAX_FIELDS:   maxf_q    <= cfg_wdata_i[7:0];
        REG_IGNORE_LEAD:  ign_q     <= cfg_wdata_i[0];
        REG_STRIP_QUOTES: strip_q   <= cfg_wdata_i[0];
        REG_COL_WIDTHS:   cwidths_q <= cfg_wdata_i;
        REG_COL_COUNT:    ccount_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic          item_vld_q;
  logic [7:0]    byte_q;
  logic          eol_q;
  logic          cont_q;
  logic [PW-1:0] pos_q;

  // Line state.
  logic [OW-1:0]   off_q;
  logic [CW-1:0]   cst_q;
  logic [7:0]      fcnt_q;
  logic            inq_q;
  logic            intok_q;
  logic [3:0]      cidx_q;
  logic [CW-1:0]   cend_q;
  logic [3:0][7:0] edge_q;
  logic            trunc_q;

  // Result register.
  logic        out_vld_q;
  logic        fv_q;
  logic [7:0]  fnum_q;
  logic [11:0] fst_q;
  logic [12:0] flen_q;
  logic        ldone_q;
  logic        tlong_q;

  // Step logic.
  logic            first, zero_off, trunc_w, dl, live;
  logic [PW-1:0]   pos;
  logic [OW-1:0]   nxt, off_d;
  logic [2:0]      dn;
  logic [7:0]      dbyte;
  logic [3:0]      num;
  logic [CW-1:0]   w_cst, w_cend;
  logic [3:0]      w_cidx;
  logic            f_fit, f_cond, f_more;
  logic [CW-1:0]   f_end, f_cend;
  logic [3:0]      f_cidx;
  logic [CW-1:0]   n_cst, n_cend;
  logic [3:0]      n_cidx;
  logic            n_intok, n_inq;
  logic [3:0][7:0] n_edge;
  logic [7:0]      n_fcnt;
  logic            em_req, em_ok, csv_pair, more;
  logic [CW-1:0]   em_s, em_e;
  logic [1:0]      trims;
  logic [PW-1:0]   s_sat, s_out;
  logic [OW-1:0]   e_sat, len, len_out;
  logic            t1, t2;
  logic            produce, bare, ldone, out_space, fire, item_done;

  always_comb begin
    first    = !cont_q;
    zero_off = (off_q == '0);
    trunc_w  = trunc_q | (first && (off_q >= LB_O));
    if (!first) begin
      pos = pos_q;
    end else if (off_q >= LB_O) begin
      pos = LAST_P;
    end else begin
      pos = PW'(off_q);
    end
    nxt   = OW'(pos) + OW'(1);
    off_d = (first && (off_q < LB_O)) ? off_q + OW'(1) : off_q;

    dn   = (dcount_q > MAX_DELIMS) ? MAX_DELIMS : dcount_q;
    live = 1'b1;
    dl   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      dbyte = dbytes_q[8*k +: 8];
      if (3'(k) < dn) begin
        if (dbyte == 8'h00) live = 1'b0;
        if (live && (dbyte == byte_q)) dl = 1'b1;
      end
    end

    num = (ccount_q > MAX_COLUMNS) ? MAX_COLUMNS : ccount_q;
    if ((maxf_q != '0) && ({4'b0000, num} > maxf_q)) num = maxf_q[3:0];

    w_cst  = (first && zero_off) ? '0 : cst_q;
    w_cidx = (first && zero_off) ? '0 : cidx_q;
    w_cend = (first && zero_off) ? CW'(col_width(cwidths_q, 3'd0)) : cend_q;

    f_fit  = (w_cend <= CW'(nxt));
    f_cond = (w_cidx < num) && (w_cst <= CW'(pos)) && (f_fit || eol_q);
    f_end  = f_fit ? w_cend : CW'(nxt);
    f_cidx = w_cidx + 4'd1;
    f_cend = f_end + CW'(col_width(cwidths_q, f_cidx[2:0]));
    f_more = (f_cidx < num) && (f_end <= CW'(pos)) && ((f_cend <= CW'(nxt)) || eol_q);

    n_cst    = w_cst;
    n_cidx   = w_cidx;
    n_cend   = w_cend;
    n_intok  = intok_q;
    n_inq    = inq_q;
    n_edge   = edge_q;
    em_req   = 1'b0;
    em_s     = w_cst;
    em_e     = CW'(nxt);
    trims    = {1'b0, strip_q};
    csv_pair = 1'b0;
    more     = 1'b0;

    if (first) begin
      unique case (mode_q)
        MODE_AGG: begin
          if (dl) begin
            if (intok_q) begin
              em_req  = 1'b1;
              em_e    = CW'(pos);
              n_intok = 1'b0;
            end
          end else begin
            if (!intok_q) begin
              n_intok = 1'b1;
              n_cst   = CW'(pos);
            end
            n_edge = rec_edges(edge_q, byte_q, pos, n_cst);
            em_s   = n_cst;
            em_req = eol_q;
          end
        end
        MODE_STRICT: begin
          if (dl) begin
            em_req = !(zero_off && ign_q);
            em_e   = CW'(pos);
            n_cst  = CW'(nxt);
          end else begin
            n_edge = rec_edges(edge_q, byte_q, pos, w_cst);
            em_req = eol_q;
          end
        end
        MODE_CSV: begin
          trims = {1'b0, strip_q} + 2'd1;
          if ((byte_q == COMMA_BYTE) && !inq_q) begin
            em_req   = 1'b1;
            em_e     = CW'(pos);
            n_cst    = CW'(nxt);
            csv_pair = eol_q;
          end else begin
            if (byte_q == QUOTE_BYTE) n_inq = !inq_q;
            n_edge = rec_edges(edge_q, byte_q, pos, w_cst);
            em_req = eol_q;
          end
        end
        MODE_FIXED: begin
          n_edge = rec_edges(edge_q, byte_q, pos, w_cst);
          em_req = f_cond;
          em_e   = f_end;
          if (f_cond) begin
            n_cst  = f_end;
            n_cidx = f_cidx;
            n_cend = f_cend;
            more   = f_more;
          end
        end
        default: ;
      endcase
    end else if (mode_q == MODE_FIXED) begin
      em_req = f_cond;
      em_e   = f_end;
      if (f_cond) begin
        n_cst  = f_end;
        n_cidx = f_cidx;
        n_cend = f_cend;
        more   = f_more;
      end
    end else begin
      // The empty closing field after a comma on the last byte of a csv line.
      trims  = {1'b0, strip_q} + 2'd1;
      em_req = 1'b1;
      em_s   = w_cst;
      em_e   = w_cst;
    end

    em_ok  = em_req && ((maxf_q == '0) || (fcnt_q < maxf_q));
    n_fcnt = (em_ok && (fcnt_q != 8'hFF)) ? fcnt_q + 8'd1 : fcnt_q;
    if (csv_pair) more = (maxf_q == '0) || (n_fcnt < maxf_q);

    s_sat   = (em_s > LAST_C) ? LAST_P : PW'(em_s);
    e_sat   = (em_e > LB_C) ? LB_O : OW'(em_e);
    len     = (OW'(s_sat) < e_sat) ? e_sat - OW'(s_sat) : '0;
    t1      = (trims != 2'd0) && (len >= OW'(2)) &&
              (n_edge[0] == QUOTE_BYTE) && (n_edge[3] == QUOTE_BYTE);
    t2      = t1 && (trims == 2'd2) && (len >= OW'(4)) &&
              (n_edge[1] == QUOTE_BYTE) && (n_edge[2] == QUOTE_BYTE);
    s_out   = s_sat + PW'(t1) + PW'(t2);
    len_out = len - (t1 ? OW'(2) : '0) - (t2 ? OW'(2) : '0);

    ldone     = eol_q && !more;
    bare      = ldone && !em_ok;
    produce   = em_ok || bare;
    out_space = !out_vld_q || out_ready_i;
    fire      = item_vld_q && (out_space || !produce);
    item_done = fire && !more;
  end

  assign in_ready_o = !item_vld_q || item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      cont_q     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        item_vld_q <= 1'b1;
        cont_q     <= 1'b0;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
        cont_q     <= 1'b0;
      end else if (fire) begin
        cont_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= char_byte_i;
      eol_q  <= end_of_line_i;
    end
    if (fire && more) begin
      pos_q <= pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      cst_q   <= '0;
      fcnt_q  <= '0;
      inq_q   <= 1'b0;
      intok_q <= 1'b0;
      cidx_q  <= '0;
      cend_q  <= '0;
      edge_q  <= '0;
      trunc_q <= 1'b0;
    end else if (fire) begin
      if (item_done && eol_q) begin
        off_q   <= '0;
        cst_q   <= '0;
        fcnt_q  <= '0;
        inq_q   <= 1'b0;
        intok_q <= 1'b0;
        cidx_q  <= '0;
        cend_q  <= '0;
        edge_q  <= '0;
        trunc_q <= 1'b0;
      end else begin
        off_q   <= off_d;
        cst_q   <= n_cst;
        fcnt_q  <= n_fcnt;
        inq_q   <= n_inq;
        intok_q <= n_intok;
        cidx_q  <= n_cidx;
        cend_q  <= n_cend;
        edge_q  <= n_edge;
        trunc_q <= trunc_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && produce) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produce) begin
      fv_q    <= em_ok;
      fnum_q  <= em_ok ? fcnt_q : '0;
      fst_q   <= em_ok ? 12'(s_out) : '0;
      flen_q  <= em_ok ? 13'(len_out) : '0;
      ldone_q <= ldone;
      tlong_q <= trunc_w;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign field_valid_o   = fv_q;
  assign field_number_o  = fnum_q;
  assign field_start_o   = fst_q;
  assign field_length_o  = flen_q;
  assign line_done_o     = ldone_q;
  assign line_too_long_o = tlong_q;

endmodule

FILE: src/lfs_checker.sv
`timescale 1ns / 1ps

module lfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        field_valid_o,
  input logic [7:0]  field_number_o,
  input logic [11:0] field_start_o,
  input logic [12:0] field_length_o,
  input logic        line_done_o,
  input logic        line_too_long_o
);

  // A result beat that the sink stalls must be shown again unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({field_valid_o, field_number_o, field_start_o, field_length_o,
               line_done_o, line_too_long_o}))
    else $error("stalled result beat changed");

  // A beat without a field is only ever a closing line-end beat.
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !field_valid_o |-> line_done_o && field_number_o == 8'd0 &&
      field_start_o == 12'd0 && field_length_o == 13'd0)
    else $error("bare line end beat has a nonzero descriptor");

  // Nothing is offered on the output right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat offered out of reset");

  // An idle input side with nothing pending downstream must be ready.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_o && $past(!in_valid_i) && $past(!out_valid_o) &&
      $past(in_ready_o) |-> in_ready_o)
    else $error("input not ready while the block is idle");

endmodule

bind line_field_splitter_top lfs_checker u_lfs_checker (.*);
